>>> rtl/bbpa_pkg.sv
// ----------------------------------------------------------------------------
// bbpa_pkg
// Shared types and constants for the bitmap block pool allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bbpa_pkg;

    localparam int MAX_BLOCKS  = 256;
    localparam int IDX_W       = $clog2(MAX_BLOCKS);
    localparam int LANES       = 16;
    localparam int LANE_W      = $clog2(LANES);
    localparam int GRP_W       = IDX_W - LANE_W;

    localparam int ADDR_W      = 32;
    localparam int SIZE_W      = 16;
    localparam int COUNT_W     = 9;
    localparam int STATUS_W    = 2;
    localparam int DIV_CNT_W   = $clog2(ADDR_W);
    localparam int PROD_W      = IDX_W + SIZE_W;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 40;

    localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_MUL,
        S_ADD,
        S_DIV,
        S_FREE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic scan;
        logic mul;
        logic alloc_commit;
        logic alloc_fail;
        logic reject;
        logic div_start;
        logic div_step;
        logic free_commit;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic is_free;
        logic pre_bad;
        logic scan_hit;
        logic scan_last;
        logic div_last;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/bbpa_ctrl.sv
// ----------------------------------------------------------------------------
// bbpa_ctrl
// Sequencer for allocate and free requests; owns both handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbpa_ctrl (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  wire              m_tready,
    input  wire bbpa_pkg::dp_stat_t stat,
    output bbpa_pkg::dp_cmd_t  cmd
);
    import bbpa_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        s_tready      = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (!stat.is_free) begin
                    state_next = S_SCAN;
                end else if (stat.pre_bad) begin
                    cmd.reject = 1'b1;
                    state_next = S_OUT;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_hit) begin
                    state_next = S_MUL;
                end else if (stat.scan_last) begin
                    cmd.alloc_fail = 1'b1;
                    state_next     = S_OUT;
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_ADD;
            end
            S_ADD: begin
                cmd.alloc_commit = 1'b1;
                state_next       = S_OUT;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = S_FREE;
                end
            end
            S_FREE: begin
                cmd.free_commit = 1'b1;
                state_next      = S_OUT;
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

>>> rtl/bbpa_dp.sv
// ----------------------------------------------------------------------------
// bbpa_dp
// Datapath: configuration registers, occupancy map, group scan,
// address multiply-add, restoring divider and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbpa_dp (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cfg_we,
    input  wire  [bbpa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [bbpa_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire  [bbpa_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire                                s_command,
    output logic [bbpa_pkg::M_TDATA_W-1:0]     m_tdata,
    input  wire  bbpa_pkg::dp_cmd_t            cmd,
    output bbpa_pkg::dp_stat_t                 stat
);
    import bbpa_pkg::*;

    logic [ADDR_W-1:0]     pool_base_reg;
    logic [SIZE_W-1:0]     chunk_size_reg;
    logic [COUNT_W-1:0]    block_count_reg;

    logic                  command_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic [MAX_BLOCKS-1:0] map_reg;
    logic [GRP_W-1:0]      grp_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [SIZE_W-1:0]     rem_reg;
    logic [ADDR_W-1:0]     quo_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [STATUS_W-1:0]   res_status_reg;
    logic [ADDR_W-1:0]     res_addr_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [ADDR_W-1:0]     out_addr_reg;

    logic [SIZE_W-1:0]     sz;
    logic [COUNT_W-1:0]    n;
    logic [LANES-1:0]      lane_free;
    logic                  hit;
    logic [LANE_W-1:0]     hit_lane;
    logic [SIZE_W:0]       rem_shift;
    logic                  rem_ge;
    logic [SIZE_W-1:0]     rem_next;
    logic                  free_bad;

    assign sz = (chunk_size_reg == '0) ? SIZE_W'(1) : chunk_size_reg;
    assign n  = (block_count_reg > COUNT_W'(MAX_BLOCKS)) ? COUNT_W'(MAX_BLOCKS)
                                                         : block_count_reg;

    always_comb begin
        hit      = 1'b0;
        hit_lane = '0;
        for (int j = 0; j < LANES; j++) begin
            lane_free[j] = !map_reg[{grp_reg, LANE_W'(j)}]
                         && (COUNT_W'({grp_reg, LANE_W'(j)}) < n);
        end
        for (int j = LANES - 1; j >= 0; j--) begin
            if (lane_free[j]) begin
                hit      = 1'b1;
                hit_lane = LANE_W'(j);
            end
        end
    end

    assign rem_shift = {rem_reg, quo_reg[ADDR_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, sz};
    assign rem_next  = rem_ge ? SIZE_W'(rem_shift - {1'b0, sz}) : rem_shift[SIZE_W-1:0];
    assign free_bad  = (rem_reg != '0) || (quo_reg >= ADDR_W'(n));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_base_reg   <= '0;
            chunk_size_reg  <= SIZE_W'(1);
            block_count_reg <= COUNT_W'(MAX_BLOCKS);
            map_reg         <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_POOL_BASE:   pool_base_reg   <= cfg_wdata[ADDR_W-1:0];
                    REG_CHUNK_SIZE:  chunk_size_reg  <= cfg_wdata[SIZE_W-1:0];
                    REG_BLOCK_COUNT: block_count_reg <= cfg_wdata[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.scan && hit) begin
                map_reg[{grp_reg, hit_lane}] <= 1'b1;
            end
            if (cmd.free_commit && !free_bad) begin
                map_reg[quo_reg[IDX_W-1:0]] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            command_reg <= s_command;
            addr_reg    <= s_tdata[ADDR_W-1:0];
            grp_reg     <= '0;
        end
        if (cmd.scan) begin
            grp_reg <= grp_reg + GRP_W'(1);
            if (hit) begin
                idx_reg <= {grp_reg, hit_lane};
            end
        end
        if (cmd.mul) begin
            prod_reg <= PROD_W'(idx_reg) * PROD_W'(sz);
        end
        if (cmd.div_start) begin
            quo_reg <= addr_reg - pool_base_reg;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        if (cmd.div_step) begin
            quo_reg <= {quo_reg[ADDR_W-2:0], rem_ge};
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + DIV_CNT_W'(1);
        end
        if (cmd.alloc_commit) begin
            res_status_reg <= ST_DONE;
            res_addr_reg   <= pool_base_reg + ADDR_W'(prod_reg);
        end
        if (cmd.alloc_fail) begin
            res_status_reg <= ST_FULL;
            res_addr_reg   <= '0;
        end
        if (cmd.reject) begin
            res_status_reg <= ST_BAD;
            res_addr_reg   <= '0;
        end
        if (cmd.free_commit) begin
            res_status_reg <= free_bad ? ST_BAD : ST_DONE;
            res_addr_reg   <= '0;
        end
        if (cmd.out_load) begin
            out_status_reg <= res_status_reg;
            out_addr_reg   <= res_addr_reg;
        end
    end

    assign stat.is_free   = (command_reg == CMD_FREE);
    assign stat.pre_bad   = (addr_reg == '0) || (addr_reg < pool_base_reg);
    assign stat.scan_hit  = hit;
    assign stat.scan_last = (grp_reg == '1);
    assign stat.div_last  = (cnt_reg == '1);

    assign m_tdata = {{(M_TDATA_W - STATUS_W - ADDR_W){1'b0}}, out_addr_reg, out_status_reg};

endmodule

`default_nettype wire

>>> rtl/bitmap_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_pool_allocator
// First-fit fixed-size block pool allocator with a one-bit-per-block map.
//
// Configure the pool base, chunk size and block count through cfg_we/
// cfg_index/cfg_wdata while the block is idle. Requests arrive on the s_
// stream: s_tuser[0] is the command (0 allocate, 1 free), s_tdata the address
// to free. Each request gives one result transfer on the m_ stream with the
// status and the allocated block address.
// One request is worked at a time. An allocate scans the map 16 blocks a
// cycle and reports full when no block is free; a free runs a
// one-bit-per-cycle restoring divider over the 32-bit offset, unless the
// address is rejected up front. The block returns to idle after loading
// each result, and accepts the next transfer only from there.
// Reset marks all blocks free and loads base 0, size 1, count 256.
// A finished result waits in the output register while m_tready is low;
// the next request is accepted meanwhile, and its result holds until the
// output register frees up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bitmap_block_pool_allocator (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cfg_we,
    input  wire  [bbpa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [bbpa_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  [bbpa_pkg::S_TDATA_W-1:0]     s_tdata,   // [31:0] address
    input  wire  [0:0]                         s_tuser,   // [0] command
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [bbpa_pkg::M_TDATA_W-1:0]     m_tdata    // [1:0] status, [33:2] block_address
);
    import bbpa_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bbpa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bbpa_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_command (s_tuser[0]),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire
